@@ rtl/two_register_cpu_instruction_step_defines.svh @@
// Assertion macros for the instruction step RTL.
`ifndef TWO_REGISTER_CPU_INSTRUCTION_STEP_DEFINES_SVH
`define TWO_REGISTER_CPU_INSTRUCTION_STEP_DEFINES_SVH

// Plain property, checked on every rising clock edge outside reset.
`define TRCIS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define TRCIS_ASSERT_IMP(lbl, ante, cons, msg) \
  `TRCIS_ASSERT(lbl, (ante) |-> (cons), msg)

// Next-cycle implication.
`define TRCIS_ASSERT_NXT(lbl, ante, cons, msg) \
  `TRCIS_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

@@ rtl/trcis_pkg.sv @@
// Shared constants and types for the two-register CPU instruction step.
package trcis_pkg;

  localparam int unsigned WORD_W    = 16;
  localparam int unsigned PC_W      = 15;
  localparam int unsigned CONST_W   = 15;
  localparam int unsigned RAM_DEPTH = 1024;
  localparam int unsigned ADDR_W    = $clog2(RAM_DEPTH);

  // ALU option bits of a compute instruction.
  typedef struct packed {
    logic zx;
    logic nx;
    logic zy;
    logic ny;
    logic f;
    logic no;
  } alu_ctrl_t;

  // Bit layout of one instruction word, most significant bit first.
  typedef struct packed {
    logic       is_c;
    logic [1:0] spare;
    logic       use_m;
    alu_ctrl_t  alu;
    logic       dst_a;
    logic       dst_d;
    logic       dst_m;
    logic       j_lt;
    logic       j_eq;
    logic       j_gt;
  } instr_t;

  // Everything one result beat carries.
  typedef struct packed {
    logic [PC_W-1:0]          next_pc;
    logic [WORD_W-1:0]        a_value;
    logic signed [WORD_W-1:0] d_value;
    logic signed [WORD_W-1:0] alu_value;
    logic                     alu_eq_zero;
    logic                     alu_negative;
    logic                     memory_written;
    logic                     fault;
  } result_t;

endpackage

@@ rtl/trcis_if.sv @@
// Valid/ready channel interfaces for instruction and result beats.
interface trcis_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] instruction;

  modport source (output valid, output instruction, input ready);
  modport sink (input valid, input instruction, output ready);
endinterface

interface trcis_out_if;
  logic               valid;
  logic               ready;
  logic [14:0]        next_pc;
  logic [15:0]        a_value;
  logic signed [15:0] d_value;
  logic signed [15:0] alu_value;
  logic               alu_eq_zero;
  logic               alu_negative;
  logic               memory_written;
  logic               fault;

  modport source (output valid, output next_pc, output a_value, output d_value,
                  output alu_value, output alu_eq_zero, output alu_negative,
                  output memory_written, output fault, input ready);
  modport sink (input valid, input next_pc, input a_value, input d_value,
                input alu_value, input alu_eq_zero, input alu_negative,
                input memory_written, input fault, output ready);
endinterface

@@ rtl/trcis_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module trcis_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port; the read returns the old word on a same-address write.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/trcis_alu.sv @@
// Operand conditioning, add/and function and result flags of the ALU.
module trcis_alu (
  input  logic [trcis_pkg::WORD_W-1:0] x_i,
  input  logic [trcis_pkg::WORD_W-1:0] y_i,
  input  trcis_pkg::alu_ctrl_t         ctrl_i,
  output logic [trcis_pkg::WORD_W-1:0] res_o,
  output logic                         zero_o,
  output logic                         neg_o
);

  logic [trcis_pkg::WORD_W-1:0] x_z, x_c, y_z, y_c, f_out;

  // Zero and then invert each operand.
  assign x_z = ctrl_i.zx ? '0 : x_i;
  assign x_c = ctrl_i.nx ? ~x_z : x_z;
  assign y_z = ctrl_i.zy ? '0 : y_i;
  assign y_c = ctrl_i.ny ? ~y_z : y_z;

  // Add wraps at the word width; otherwise bitwise AND.
  assign f_out = ctrl_i.f ? (x_c + y_c) : (x_c & y_c);
  assign res_o = ctrl_i.no ? ~f_out : f_out;

  assign zero_o = (res_o == '0);
  assign neg_o  = res_o[trcis_pkg::WORD_W-1];

endmodule

@@ rtl/trcis_exec.sv @@
// Architectural state, data memory and single-pass execution of one instruction.
`include "two_register_cpu_instruction_step_defines.svh"

module trcis_exec (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  trcis_pkg::instr_t   instr_i,
  output logic                busy_o,
  output trcis_pkg::result_t  result_o
);

  localparam int unsigned WW = trcis_pkg::WORD_W;
  localparam int unsigned PW = trcis_pkg::PC_W;
  localparam int unsigned AW = trcis_pkg::ADDR_W;
  localparam logic [WW:0]   DepthLim = (WW+1)'(trcis_pkg::RAM_DEPTH);
  localparam logic [AW-1:0] LastAddr = AW'(trcis_pkg::RAM_DEPTH - 1);

  logic [WW-1:0] a_q, a_d, a_n;
  logic [WW-1:0] d_q, d_d, d_n;
  logic [PW-1:0] pc_q, pc_d, pc_n, pc_inc;
  logic [WW-1:0] alu_q, alu_d, alu_n;
  logic          zf_q, zf_d, zf_n;
  logic          nf_q, nf_d, nf_n;

  logic          clearing_q, clearing_d;
  logic [AW-1:0] clr_cnt_q, clr_cnt_d;

  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [WW-1:0] mem_wdata, mem_rdata, m_val;
  logic          fwd_q, fwd_d;
  logic [WW-1:0] fwd_data_q;

  logic [WW-1:0] ins_bits, y_op, res;
  logic          zr, ng, in_range, fault, take, store;

  assign ins_bits = instr_i;

  // Memory word at the current A; a write in the previous cycle is forwarded.
  assign m_val = fwd_q ? fwd_data_q : mem_rdata;

  // M is touched only inside the memory; otherwise the instruction faults.
  assign in_range = ({1'b0, a_q} < DepthLim);
  assign fault    = instr_i.is_c & (instr_i.use_m | instr_i.dst_m) & ~in_range;

  assign y_op = instr_i.use_m ? m_val : a_q;

  trcis_alu u_alu (
    .x_i    (d_q),
    .y_i    (y_op),
    .ctrl_i (instr_i.alu),
    .res_o  (res),
    .zero_o (zr),
    .neg_o  (ng)
  );

  // Jump test on the fresh result flags.
  assign take = (instr_i.j_lt & ng) | (instr_i.j_eq & zr) | (instr_i.j_gt & ~zr & ~ng);
  assign pc_inc = pc_q + PW'(1);

  // State after this instruction.
  always_comb begin
    a_n   = a_q;
    d_n   = d_q;
    pc_n  = pc_q;
    alu_n = alu_q;
    zf_n  = zf_q;
    nf_n  = nf_q;
    store = 1'b0;
    priority if (!instr_i.is_c) begin
      a_n  = {1'b0, ins_bits[trcis_pkg::CONST_W-1:0]};
      pc_n = pc_inc;
    end else if (fault) begin
      // A faulting instruction leaves everything as it was.
    end else begin
      alu_n = res;
      zf_n  = zr;
      nf_n  = ng;
      store = instr_i.dst_m;
      if (instr_i.dst_a) begin
        a_n = res;
      end
      if (instr_i.dst_d) begin
        d_n = res;
      end
      pc_n = take ? a_q[PW-1:0] : pc_inc;
    end
  end

  assign a_d   = fire_i ? a_n : a_q;
  assign d_d   = fire_i ? d_n : d_q;
  assign pc_d  = fire_i ? pc_n : pc_q;
  assign alu_d = fire_i ? alu_n : alu_q;
  assign zf_d  = fire_i ? zf_n : zf_q;
  assign nf_d  = fire_i ? nf_n : nf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q   <= '0;
      d_q   <= '0;
      pc_q  <= '0;
      alu_q <= '0;
      zf_q  <= 1'b0;
      nf_q  <= 1'b0;
    end else begin
      a_q   <= a_d;
      d_q   <= d_d;
      pc_q  <= pc_d;
      alu_q <= alu_d;
      zf_q  <= zf_d;
      nf_q  <= nf_d;
    end
  end

  // Clearing pass after reset: one word per cycle, zero written.
  assign clearing_d = clearing_q && (clr_cnt_q != LastAddr);
  assign clr_cnt_d  = clearing_q ? clr_cnt_q + AW'(1) : clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else begin
      clearing_q <= clearing_d;
      clr_cnt_q  <= clr_cnt_d;
    end
  end

  assign busy_o = clearing_q;

  // Memory ports: the read address tracks the next A so the word is ready in time.
  assign mem_we    = clearing_q | (fire_i & store);
  assign mem_waddr = clearing_q ? clr_cnt_q : a_q[AW-1:0];
  assign mem_wdata = clearing_q ? '0 : res;
  assign mem_raddr = a_d[AW-1:0];
  assign fwd_d     = mem_we && (mem_waddr == mem_raddr);

  trcis_ram #(
    .Width (WW),
    .Depth (trcis_pkg::RAM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Forwarding register for a read that collides with a write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else begin
      fwd_q <= fwd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= mem_wdata;
  end

  // Result beat for this instruction.
  always_comb begin
    result_o.next_pc        = pc_n;
    result_o.a_value        = a_n;
    result_o.d_value        = signed'(d_n);
    result_o.alu_value      = signed'(alu_n);
    result_o.alu_eq_zero    = zf_n;
    result_o.alu_negative   = nf_n;
    result_o.memory_written = store;
    result_o.fault          = fault;
  end

  `TRCIS_ASSERT_IMP(fault_no_store_a, fire_i && result_o.fault, !mem_we, "store on fault")
  `TRCIS_ASSERT_IMP(clear_blocks_exec_a, clearing_q, !fire_i && busy_o, "exec while clearing")
  `TRCIS_ASSERT_NXT(fault_holds_state_a, fire_i && result_o.fault,
                    $stable(a_q) && $stable(d_q) && $stable(pc_q) && $stable(alu_q),
                    "state moved on fault")
  `TRCIS_ASSERT_NXT(load_holds_alu_a, fire_i && !instr_i.is_c,
                    $stable(alu_q) && $stable(zf_q) && !a_q[WW-1],
                    "constant load disturbed ALU state")

endmodule

@@ rtl/two_register_cpu_instruction_step.sv @@
// An accepted beat waits in the input register until it executes; its result
// beat is then held in the result register. Throughput: one instruction per
// cycle while results are taken and no clearing runs; the registers are parted
// so a new beat enters while a result waits. Reset: A, D, PC, ALU result, flags
// go to 0; the 1024 memory words then clear one per cycle, taking no beat.
module two_register_cpu_instruction_step (
  input  logic         clk_i,
  input  logic         rst_ni,
  trcis_in_if.sink     in_i,
  trcis_out_if.source  out_o
);

  trcis_pkg::instr_t  ins_q;
  logic               ins_vld_q, ins_vld_d;
  trcis_pkg::result_t out_q, exec_res;
  logic               out_vld_q, out_vld_d;
  logic               exec_fire, in_take, busy;

  // Execute when the result register is free or being drained.
  assign exec_fire = ins_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !busy && (!ins_vld_q || exec_fire);
  assign in_take    = in_i.valid && in_i.ready;

  assign ins_vld_d = in_take ? 1'b1 : (exec_fire ? 1'b0 : ins_vld_q);
  assign out_vld_d = exec_fire ? 1'b1 : (out_o.ready ? 1'b0 : out_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ins_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      ins_vld_q <= ins_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      ins_q <= trcis_pkg::instr_t'(in_i.instruction);
    end
    if (exec_fire) begin
      out_q <= exec_res;
    end
  end

  trcis_exec u_exec (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (exec_fire),
    .instr_i  (ins_q),
    .busy_o   (busy),
    .result_o (exec_res)
  );

  // Result channel.
  assign out_o.valid          = out_vld_q;
  assign out_o.next_pc        = out_q.next_pc;
  assign out_o.a_value        = out_q.a_value;
  assign out_o.d_value        = out_q.d_value;
  assign out_o.alu_value      = out_q.alu_value;
  assign out_o.alu_eq_zero    = out_q.alu_eq_zero;
  assign out_o.alu_negative   = out_q.alu_negative;
  assign out_o.memory_written = out_q.memory_written;
  assign out_o.fault          = out_q.fault;

endmodule
